### rtl/pobd_pkg.sv
// shared constants and register index codes for the oriented box distance unit
package pobd_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;

  // isqrt steps folded into one pipeline stage
  localparam int SQRT_STEPS = 2;

  localparam int CFG_IDX_W = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X = 4'd0,
    REG_CENTER_Y = 4'd1,
    REG_AXIS0_X  = 4'd2,
    REG_AXIS0_Y  = 4'd3,
    REG_AXIS1_X  = 4'd4,
    REG_AXIS1_Y  = 4'd5,
    REG_EXTENT0  = 4'd6,
    REG_EXTENT1  = 4'd7
  } cfg_idx_t;

endpackage

### rtl/pobd_sqrt.sv
// pipelined integer square root, floor, with payload carried alongside
module pobd_sqrt
  import pobd_pkg::*;
#(
  parameter int VW   = 63,
  parameter int PAYW = 127
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_vld,
  input  logic [VW-1:0]          in_val,
  input  logic [PAYW-1:0]        in_pay,
  output logic                   out_vld,
  output logic [(VW+1)/2-1:0]    out_res,
  output logic [PAYW-1:0]        out_pay
);

  localparam int NIT = (VW + 1) / 2;
  localparam int NST = (NIT + SQRT_STEPS - 1) / SQRT_STEPS;
  localparam int RW  = VW + 1;

  logic [RW-1:0]   v_r   [NST];
  logic [RW-1:0]   res_r [NST];
  logic [PAYW-1:0] pay_r [NST];
  logic            vld_r [NST];

  for (genvar s = 0; s < NST; s++) begin : g_st
    logic [RW-1:0]   v_in, r_in, v_nxt, r_nxt;
    logic [PAYW-1:0] p_in;
    logic            vld_in;

    if (s == 0) begin : g_first
      assign v_in   = {1'b0, in_val};
      assign r_in   = '0;
      assign p_in   = in_pay;
      assign vld_in = in_vld;
    end else begin : g_next
      assign v_in   = v_r[s-1];
      assign r_in   = res_r[s-1];
      assign p_in   = pay_r[s-1];
      assign vld_in = vld_r[s-1];
    end

    always_comb begin
      logic [RW-1:0] v, r, bitv, trial;
      int k;
      v = v_in;
      r = r_in;
      for (int j = 0; j < SQRT_STEPS; j++) begin
        k = s * SQRT_STEPS + j;
        if (k < NIT) begin
          bitv  = RW'(1) << (2 * (NIT - 1 - k));
          trial = r + bitv;
          if (v >= trial) begin
            v = v - trial;
            r = (r >> 1) + bitv;
          end else begin
            r = r >> 1;
          end
        end
      end
      v_nxt = v;
      r_nxt = r;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= vld_in;
      end
      if (en) begin
        v_r[s]   <= v_nxt;
        res_r[s] <= r_nxt;
        pay_r[s] <= p_in;
      end
    end
  end

  assign out_vld = vld_r[NST-1];
  assign out_res = res_r[NST-1][NIT-1:0];
  assign out_pay = pay_r[NST-1];

endmodule

### rtl/point_oriented_box_distance_2d_unit.sv
// top level: distance from a moving point to a moving oriented box in the plane
//
// Streaming unit, one beat in and one beat out per clock when not stalled.
// Each input beat moves the point and the box center by time times velocity,
// projects their difference onto the two box axes, clamps to the half-extents,
// and returns the saturated squared distance (Q31.32 by default), its floor
// square root and the closest point on the moved box. Six arithmetic stages
// (velocity products, move and difference, axis products, clamp, squares and
// rebuild products, sums) are followed by a square-root pipeline that retires
// two root bits per stage, at a sustained rate of one beat per cycle when not
// stalled. A stall on the result side while a result is held freezes the whole
// pipe. Configuration registers are written through the cfg port, always ready;
// the user must write them only while no beat is in flight, which the block does
// not enforce. Unknown indexes are dropped.
module point_oriented_box_distance_2d_unit
  import pobd_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // config write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [((COORD_WIDTH > FRAC_BITS + 2) ? COORD_WIDTH : FRAC_BITS + 2)-1:0] cfg_data,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] in_point_x,
  input  logic signed [COORD_WIDTH-1:0] in_point_y,
  input  logic signed [COORD_WIDTH-1:0] in_time_t,
  input  logic signed [COORD_WIDTH-1:0] in_point_vel_x,
  input  logic signed [COORD_WIDTH-1:0] in_point_vel_y,
  input  logic signed [COORD_WIDTH-1:0] in_box_vel_x,
  input  logic signed [COORD_WIDTH-1:0] in_box_vel_y,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [((2*COORD_WIDTH-1 < 63) ? 2*COORD_WIDTH-1 : 63)-1:0] out_squared_distance,
  output logic [COORD_WIDTH-2:0]        out_distance,
  output logic signed [COORD_WIDTH-1:0] out_closest_x,
  output logic signed [COORD_WIDTH-1:0] out_closest_y
);

  localparam int W    = COORD_WIDTH;
  localparam int F    = FRAC_BITS;
  localparam int AW   = F + 2;
  localparam int EW   = W - 1;
  localparam int SQW  = (2 * W - 1 < 63) ? 2 * W - 1 : 63;
  localparam int NIT  = (SQW + 1) / 2;
  localparam int PW   = W + 5;           // projection width
  localparam int CPW  = W + 1 + AW;      // difference times axis
  localparam int QPW  = W - 1 + AW;      // clamped times axis
  localparam int PAYW = 2 * W + SQW;
  localparam int CMW  = NIT + W;         // compare width for distance clamp

  localparam logic [SQW-1:0] SQ_LIM = '1;
  localparam logic [W:0]     MOVE_LIM = (W + 1)'(1) << W;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic signed [W-1:0]  center_x_r, center_y_r;
  logic signed [AW-1:0] axis_r [4];      // ax0, ay0, ax1, ay1
  logic [EW-1:0]        extent_r [2];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r  <= '0;
      center_y_r  <= '0;
      axis_r[0]   <= AW'(1) << F;
      axis_r[1]   <= '0;
      axis_r[2]   <= '0;
      axis_r[3]   <= AW'(1) << F;
      extent_r[0] <= EW'(1) << F;
      extent_r[1] <= EW'(1) << F;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        REG_CENTER_X: center_x_r  <= cfg_data[W-1:0];
        REG_CENTER_Y: center_y_r  <= cfg_data[W-1:0];
        REG_AXIS0_X:  axis_r[0]   <= cfg_data[AW-1:0];
        REG_AXIS0_Y:  axis_r[1]   <= cfg_data[AW-1:0];
        REG_AXIS1_X:  axis_r[2]   <= cfg_data[AW-1:0];
        REG_AXIS1_Y:  axis_r[3]   <= cfg_data[AW-1:0];
        REG_EXTENT0:  extent_r[0] <= cfg_data[EW-1:0];
        REG_EXTENT1:  extent_r[1] <= cfg_data[EW-1:0];
        default: ;
      endcase
    end
  end

  // axis magnitudes and signs, static only if the user writes no axis while beats are in flight
  logic [AW-1:0] ax_mag [4];
  logic          ax_neg [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      ax_neg[k] = axis_r[k][AW-1];
      ax_mag[k] = ax_neg[k] ? AW'(-axis_r[k]) : AW'(axis_r[k]);
    end
  end

  // saturate a W+2 signed value into W bits
  function automatic logic signed [W-1:0] sat_w(input logic signed [W+1:0] v);
    logic [2:0] top;
    top = v[W+1:W-1];
    if (top == 3'b000 || top == 3'b111) begin
      return v[W-1:0];
    end
    return v[W+1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
  endfunction

  // global advance: the whole pipe moves unless a finished beat is held
  logic en;
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // ---------------------------------------------------------------------------
  // stage a: time times velocity magnitudes
  // ---------------------------------------------------------------------------
  logic              a_vld_r;
  logic [2*W-1:0]    a_prod_r [4];       // point x, point y, box x, box y
  logic              a_neg_r  [4];
  logic signed [W-1:0] a_base_r [4];

  logic [W-1:0] t_mag;
  logic [W-1:0] v_mag [4];
  logic         v_neg [4];
  logic signed [W-1:0] vel [4];

  always_comb begin
    vel[0] = in_point_vel_x;
    vel[1] = in_point_vel_y;
    vel[2] = in_box_vel_x;
    vel[3] = in_box_vel_y;
    t_mag  = in_time_t[W-1] ? W'(-in_time_t) : W'(in_time_t);
    for (int k = 0; k < 4; k++) begin
      v_neg[k] = vel[k][W-1];
      v_mag[k] = v_neg[k] ? W'(-vel[k]) : W'(vel[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= in_valid;
    end
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        a_prod_r[k] <= t_mag * v_mag[k];
        a_neg_r[k]  <= in_time_t[W-1] ^ v_neg[k];
      end
      a_base_r[0] <= in_point_x;
      a_base_r[1] <= in_point_y;
      a_base_r[2] <= center_x_r;
      a_base_r[3] <= center_y_r;
    end
  end

  // ---------------------------------------------------------------------------
  // stage b: round, clamp the move, add, saturate, take the difference
  // ---------------------------------------------------------------------------
  logic                b_vld_r;
  logic signed [W:0]   b_dx_r, b_dy_r;
  logic signed [W-1:0] b_cx_r, b_cy_r;

  logic signed [W-1:0] moved [4];

  always_comb begin
    logic [2*W:0]        rs;
    logic [W:0]          cm;
    logic signed [W+1:0] tm;
    for (int k = 0; k < 4; k++) begin
      rs = ({1'b0, a_prod_r[k]} + (2*W+1)'(1) * (2*W+1)'(2**(F-1))) >> F;
      cm = (rs > (2*W+1)'(MOVE_LIM)) ? MOVE_LIM : rs[W:0];
      tm = a_neg_r[k] ? -$signed({1'b0, cm}) : $signed({1'b0, cm});
      moved[k] = sat_w($signed({{2{a_base_r[k][W-1]}}, a_base_r[k]}) + tm);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (en) begin
      b_vld_r <= a_vld_r;
    end
    if (en) begin
      b_dx_r <= $signed({moved[0][W-1], moved[0]}) - $signed({moved[2][W-1], moved[2]});
      b_dy_r <= $signed({moved[1][W-1], moved[1]}) - $signed({moved[3][W-1], moved[3]});
      b_cx_r <= moved[2];
      b_cy_r <= moved[3];
    end
  end

  // ---------------------------------------------------------------------------
  // stage c: difference times each axis component
  // ---------------------------------------------------------------------------
  logic                c_vld_r;
  logic [CPW-1:0]      c_prod_r [4];
  logic                c_neg_r  [4];
  logic signed [W-1:0] c_cx_r, c_cy_r;

  logic [W:0] dx_mag, dy_mag;

  assign dx_mag = b_dx_r[W] ? (W+1)'(-b_dx_r) : (W+1)'(b_dx_r);
  assign dy_mag = b_dy_r[W] ? (W+1)'(-b_dy_r) : (W+1)'(b_dy_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else if (en) begin
      c_vld_r <= b_vld_r;
    end
    if (en) begin
      // even entries take dx, odd entries dy
      c_prod_r[0] <= dx_mag * ax_mag[0];
      c_prod_r[1] <= dy_mag * ax_mag[1];
      c_prod_r[2] <= dx_mag * ax_mag[2];
      c_prod_r[3] <= dy_mag * ax_mag[3];
      c_neg_r[0]  <= b_dx_r[W] ^ ax_neg[0];
      c_neg_r[1]  <= b_dy_r[W] ^ ax_neg[1];
      c_neg_r[2]  <= b_dx_r[W] ^ ax_neg[2];
      c_neg_r[3]  <= b_dy_r[W] ^ ax_neg[3];
      c_cx_r      <= b_cx_r;
      c_cy_r      <= b_cy_r;
    end
  end

  // ---------------------------------------------------------------------------
  // stage d: projections, clamp against extents, excess
  // ---------------------------------------------------------------------------
  logic                d_vld_r;
  logic [PW-1:0]       d_dmag_r [2];
  logic signed [W-1:0] d_cl_r   [2];
  logic signed [W-1:0] d_cx_r, d_cy_r;

  logic [PW-1:0]       dmag [2];
  logic signed [W-1:0] clv  [2];

  always_comb begin
    logic [CPW:0]         rr;
    logic signed [W+3:0]  tm [2];
    logic signed [PW-1:0] proj, extp, extn, delta;
    for (int i = 0; i < 2; i++) begin
      for (int j = 0; j < 2; j++) begin
        rr = ({1'b0, c_prod_r[2*i+j]} + (CPW+1)'(2**(F-1))) >> F;
        tm[j] = c_neg_r[2*i+j] ? -$signed({1'b0, rr[W+2:0]}) : $signed({1'b0, rr[W+2:0]});
      end
      proj = $signed({tm[0][W+3], tm[0]}) + $signed({tm[1][W+3], tm[1]});
      extp = $signed({{(PW-EW){1'b0}}, extent_r[i]});
      extn = -extp;
      if (proj < extn) begin
        delta  = proj + extp;
        clv[i] = extn[W-1:0];
      end else if (proj > extp) begin
        delta  = proj - extp;
        clv[i] = extp[W-1:0];
      end else begin
        delta  = '0;
        clv[i] = proj[W-1:0];
      end
      dmag[i] = delta[PW-1] ? PW'(-delta) : PW'(delta);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r <= 1'b0;
    end else if (en) begin
      d_vld_r <= c_vld_r;
    end
    if (en) begin
      d_dmag_r <= dmag;
      d_cl_r   <= clv;
      d_cx_r   <= c_cx_r;
      d_cy_r   <= c_cy_r;
    end
  end

  // ---------------------------------------------------------------------------
  // stage e: square the excess, clamped projection times axis
  // ---------------------------------------------------------------------------
  logic                e_vld_r;
  logic [2*W-1:0]      e_sq_r  [2];
  logic                e_big_r [2];
  logic [QPW-1:0]      e_prod_r [4];     // x0, y0, x1, y1
  logic                e_neg_r  [4];
  logic signed [W-1:0] e_cx_r, e_cy_r;

  logic [W-2:0] cl_mag [2];

  // clamped value never exceeds the extent, so its magnitude fits W-1 bits
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      cl_mag[i] = d_cl_r[i][W-1] ? (W-1)'(-d_cl_r[i]) : (W-1)'(d_cl_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_vld_r <= 1'b0;
    end else if (en) begin
      e_vld_r <= d_vld_r;
    end
    if (en) begin
      for (int i = 0; i < 2; i++) begin
        e_big_r[i] <= |d_dmag_r[i][PW-1:W];
        e_sq_r[i]  <= d_dmag_r[i][W-1:0] * d_dmag_r[i][W-1:0];
      end
      for (int k = 0; k < 4; k++) begin
        e_prod_r[k] <= cl_mag[k/2] * ax_mag[k];
        e_neg_r[k]  <= d_cl_r[k/2][W-1] ^ ax_neg[k];
      end
      e_cx_r <= d_cx_r;
      e_cy_r <= d_cy_r;
    end
  end

  // ---------------------------------------------------------------------------
  // stage f: saturating sum of squares, rebuild the closest point
  // ---------------------------------------------------------------------------
  logic                f_vld_r;
  logic [SQW-1:0]      f_sq_r;
  logic signed [W-1:0] f_qx_r, f_qy_r;

  logic [SQW-1:0]      sq_sum;
  logic signed [W-1:0] qx, qy;

  always_comb begin
    logic [SQW-1:0]      s [2];
    logic [SQW:0]        tot;
    logic [QPW:0]        rr;
    logic [W:0]          cm;
    logic signed [W+1:0] tm [4];
    logic signed [W-1:0] qx1, qy1;
    for (int i = 0; i < 2; i++) begin
      if (e_big_r[i] || e_sq_r[i] > (2*W)'(SQ_LIM)) begin
        s[i] = SQ_LIM;
      end else begin
        s[i] = e_sq_r[i][SQW-1:0];
      end
    end
    tot    = {1'b0, s[0]} + {1'b0, s[1]};
    sq_sum = (tot > {1'b0, SQ_LIM}) ? SQ_LIM : tot[SQW-1:0];
    for (int k = 0; k < 4; k++) begin
      rr    = ({1'b0, e_prod_r[k]} + (QPW+1)'(2**(F-1))) >> F;
      cm    = (rr > (QPW+1)'(MOVE_LIM)) ? MOVE_LIM : rr[W:0];
      tm[k] = e_neg_r[k] ? -$signed({1'b0, cm}) : $signed({1'b0, cm});
    end
    qx1 = sat_w($signed({{2{e_cx_r[W-1]}}, e_cx_r}) + tm[0]);
    qy1 = sat_w($signed({{2{e_cy_r[W-1]}}, e_cy_r}) + tm[1]);
    qx  = sat_w($signed({{2{qx1[W-1]}}, qx1}) + tm[2]);
    qy  = sat_w($signed({{2{qy1[W-1]}}, qy1}) + tm[3]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else if (en) begin
      f_vld_r <= e_vld_r;
    end
    if (en) begin
      f_sq_r <= sq_sum;
      f_qx_r <= qx;
      f_qy_r <= qy;
    end
  end

  // ---------------------------------------------------------------------------
  // square root pipeline, its last stage is the output register
  // ---------------------------------------------------------------------------
  logic [NIT-1:0]  root;
  logic [PAYW-1:0] pay_out;

  pobd_sqrt #(
    .VW   (SQW),
    .PAYW (PAYW)
  ) u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (f_vld_r),
    .in_val  (f_sq_r),
    .in_pay  ({f_qx_r, f_qy_r, f_sq_r}),
    .out_vld (out_valid),
    .out_res (root),
    .out_pay (pay_out)
  );

  // distance saturates at the largest coordinate value
  logic [CMW-1:0] root_ext, dist_max;

  assign root_ext = CMW'(root);
  assign dist_max = CMW'({(W-1){1'b1}});

  assign out_distance         = (root_ext > dist_max) ? {(W-1){1'b1}} : root_ext[W-2:0];
  assign out_squared_distance = pay_out[SQW-1:0];
  assign out_closest_y        = pay_out[SQW+W-1:SQW];
  assign out_closest_x        = pay_out[PAYW-1:SQW+W];

endmodule
